@@ src/gpds_pkg.sv @@
package gpds_pkg;

	localparam int CH_W     = 8;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 17;
	localparam int CFG_W    = 1;

	localparam logic [CH_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5B;
	localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5D;
	localparam logic [CH_W-1:0] CH_LPAREN    = 8'h28;
	localparam logic [CH_W-1:0] CH_RPAREN    = 8'h29;
	localparam logic [CH_W-1:0] CH_BAR       = 8'h7C;
	localparam logic [CH_W-1:0] CH_COLON     = 8'h3A;
	localparam logic [CH_W-1:0] CH_DOT       = 8'h2E;
	localparam logic [CH_W-1:0] CH_EQUAL     = 8'h3D;

	// Configuration register indexes.
	localparam logic CFG_DELIM_IS_BAR = 1'b0;
	localparam logic CFG_NO_ESCAPE    = 1'b1;

	typedef enum logic [5:0] {
		MODE_NORMAL     = 6'b000001,
		MODE_BRACKET    = 6'b000010,
		MODE_BRACKET_LB = 6'b000100,
		MODE_SUB        = 6'b001000,
		MODE_SKIP_AFTER = 6'b010000,
		MODE_DONE       = 6'b100000
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_CONT    = 3'd0,
		ST_FOUND   = 3'd1,
		ST_LIMIT   = 3'd2,
		ST_NOMATCH = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            at_limit;
		logic            first_char;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
	} result_t;

	typedef struct packed {
		logic delim_is_bar;
		logic no_escape;
	} cfg_t;

endpackage

@@ src/gpds_scan_core.sv @@
module gpds_scan_core #(
	parameter int MAX_PATTERN_LEN = 65536,
	parameter int MAX_PAREN_DEPTH = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  gpds_pkg::item_t  item,
	input  gpds_pkg::cfg_t   cfg,
	output gpds_pkg::result_t res
);
	import gpds_pkg::*;

	localparam int IDX_W   = $clog2(MAX_PATTERN_LEN);
	localparam int DEPTH_W = $clog2(MAX_PAREN_DEPTH + 1);
	localparam int SUM_W   = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
	localparam logic [IDX_W-1:0]   IDX_MAX   = IDX_W'(MAX_PATTERN_LEN - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_PAREN_DEPTH);

	mode_t              mode_q, mode_n;
	logic               escape_q, escape_n;
	logic [DEPTH_W-1:0] depth_q, depth_n;
	logic [IDX_W-1:0]   idx_q, idx_n;

	always_comb begin
		mode_t            m;
		logic             esc;
		logic [DEPTH_W-1:0] dep;
		logic [IDX_W-1:0] idx;
		logic             do_plain;
		logic [SUM_W-1:0] next_pos;
		status_t          st;
		logic [POS_W-1:0] pos;

		// A new scan starts from a cleared state.
		if (item.first_char) begin
			m   = MODE_NORMAL;
			esc = 1'b0;
			dep = '0;
			idx = '0;
		end else begin
			m   = mode_q;
			esc = escape_q;
			dep = depth_q;
			idx = idx_q;
		end
		do_plain = 1'b0;
		st       = ST_CONT;
		pos      = '0;
		next_pos = SUM_W'(idx) + SUM_W'(1);

		if (item.first_char && item.at_limit) begin
			m  = MODE_DONE;
			st = ST_NOMATCH;
		end else if (m == MODE_DONE) begin
			st = ST_IGNORED;
		end else begin
			if (item.ch == CH_NUL) begin
				st = ST_NOMATCH;
			end else if (item.at_limit) begin
				st  = ST_LIMIT;
				pos = POS_W'(idx);
			end else begin
				unique case (m)
					MODE_SKIP_AFTER: m = MODE_BRACKET;
					MODE_SUB: begin
						if (item.ch == CH_RBRACKET)
							m = MODE_SKIP_AFTER;
					end
					MODE_BRACKET_LB: begin
						if (item.ch == CH_COLON || item.ch == CH_DOT ||
						    item.ch == CH_EQUAL) begin
							m = MODE_SUB;
						end else begin
							m        = MODE_BRACKET;
							do_plain = 1'b1;
						end
					end
					MODE_NORMAL, MODE_BRACKET: do_plain = 1'b1;
					default: begin
						m        = MODE_NORMAL;
						do_plain = 1'b1;
					end
				endcase
			end

			// Escape, bracket, parenthesis and bar delimiter handling shared by normal and bracket text.
			if (do_plain) begin
				if (esc) begin
					esc = 1'b0;
				end else if (item.ch == CH_BACKSLASH && !cfg.no_escape) begin
					esc = 1'b1;
				end else if (m == MODE_BRACKET) begin
					if (item.ch == CH_LBRACKET)
						m = MODE_BRACKET_LB;
					else if (item.ch == CH_RBRACKET)
						m = MODE_NORMAL;
				end else if (item.ch == CH_LBRACKET) begin
					m = MODE_BRACKET;
				end else if (item.ch == CH_LPAREN) begin
					if (dep < DEPTH_MAX)
						dep = dep + DEPTH_W'(1);
				end else if (item.ch == CH_RPAREN) begin
					if (dep == '0) begin
						st  = ST_FOUND;
						pos = next_pos[POS_W-1:0];
					end else begin
						dep = dep - DEPTH_W'(1);
					end
				end else if (item.ch == CH_BAR && dep == '0 && cfg.delim_is_bar) begin
					st  = ST_FOUND;
					pos = next_pos[POS_W-1:0];
				end
			end

			if (st != ST_CONT)
				m = MODE_DONE;
			else if (idx < IDX_MAX)
				idx = idx + IDX_W'(1);
		end

		mode_n       = m;
		escape_n     = esc;
		depth_n      = dep;
		idx_n        = idx;
		res.status   = st;
		res.position = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			escape_q <= 1'b0;
			depth_q  <= '0;
			idx_q    <= '0;
		end else if (go) begin
			mode_q   <= mode_n;
			escape_q <= escape_n;
			depth_q  <= depth_n;
			idx_q    <= idx_n;
		end
	end

	a_finish_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.status != ST_CONT |=> mode_q == MODE_DONE)
		else $error("scan did not finish after a final status");

	a_escape_mode: assert property (@(posedge clk) disable iff (!arst_n)
		escape_q |-> (mode_q != MODE_SUB && mode_q != MODE_SKIP_AFTER &&
		              mode_q != MODE_BRACKET_LB))
		else $error("escape pending inside a sub-bracket");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("paren depth above its limit");

	a_ignored_holds: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.status == ST_IGNORED |=> $stable(idx_q) && $stable(depth_q))
		else $error("ignored item changed scan state");

endmodule

@@ src/glob_pattern_delimiter_scan.sv @@
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: ch[7:0]; tuser: at_limit, first_char
// m_*      out  tdata: position[16:0], zero fill to 24 bits; tuser: status[2:0]
// cfg_*    in   index 0 delim_is_bar, index 1 no_escape; data bit 0
//
// Throughput is one item per clock while the result register is not stalled.
// The item is captured in an input register, then the update of the scan
// state (mode, escape, paren depth, index) writes the result register.
// That state update loop sets the rate.
// arst_n clears the scan state, both configuration registers and all valid flags.
// A stalled result register holds the item in the input register, and
// s_tready drops only while both registers are full and m_tready is low.
module glob_pattern_delimiter_scan #(
	parameter int MAX_PATTERN_LEN = 65536,
	parameter int MAX_PAREN_DEPTH = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic [1:0]  s_tuser,   // [0] at_limit, [1] first_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // position[16:0], upper bits zero
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [gpds_pkg::CFG_W-1:0] cfg_data
);
	import gpds_pkg::*;

	logic    in_valid_s1;
	item_t   in_item_s1;
	logic    out_valid_q;
	result_t out_res_q;
	result_t res;
	cfg_t    cfg_q;
	logic    advance;
	logic    go;

	// The result register frees up when it is empty or its item is taken,
	// and the input register feeds the core whenever the result register frees up.
	assign advance  = !out_valid_q || m_tready;
	assign go       = in_valid_s1 && advance;
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELIM_IS_BAR: cfg_q.delim_is_bar <= cfg_data[0];
				CFG_NO_ESCAPE:    cfg_q.no_escape    <= cfg_data[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_item_s1.ch         <= s_tdata;
			in_item_s1.at_limit   <= s_tuser[0];
			in_item_s1.first_char <= s_tuser[1];
		end
	end

	gpds_scan_core #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN),
		.MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.item  (in_item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= go;
	end

	always_ff @(posedge clk) begin
		if (go)
			out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_res_q.position};
	assign m_tuser  = out_res_q.status;

endmodule

@@ test/glob_pattern_delimiter_scan_tb.sv @@
module glob_pattern_delimiter_scan_tb;

	import gpds_pkg::*;

	// Scan limits of the block under test, kept at the default parameters.
	localparam int MAX_PATTERN_LEN = 65536;
	localparam int MAX_PAREN_DEPTH = 255;

	// A run is declared hung when this many cycles pass with no item moving
	// on either side. The longest legal quiet stretch is the receiver hold-off
	// of HOLD_CYCLES plus a sender gap, so this leaves a wide margin.
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 100;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // ch[7:0]
	logic [1:0]  s_tuser;   // [0] at_limit, [1] first_char
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // position[16:0], upper bits zero
	logic [2:0]  m_tuser;   // status[2:0]
	logic        cfg_we;
	logic        cfg_index;
	logic [CFG_W-1:0] cfg_data;

	glob_pattern_delimiter_scan #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN),
		.MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Shadow copy of the scanner: configuration, set with each write, and
	// per-scan state, updated once for every item the block accepts.
	cfg_t             cfg_shadow;
	mode_t            sc_mode;
	logic             sc_esc;
	logic [7:0]       sc_depth;
	logic [POS_W-1:0] sc_idx;

	// Results still owed by the block, oldest first.
	result_t pending_scan_results[$];

	int      mismatch_cnt = 0;
	int      burst_left   = 0;
	status_t last_status;

	// Receiver hold-off requests, counted up by the stimulus and served by the
	// receiver process, which counts the held cycles itself.
	int hold_reqs   = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int rx_style    = 0;
	int rx_left     = 0;
	int quiet_cycles = 0;

	// One row of the directed table. Rows with known set carry a result that
	// can be read straight off the scan rules; the rest use the predictor.
	typedef struct packed {
		cfg_t             cfg;
		logic [7:0]       ch;
		logic             lim;
		logic             first;
		logic             known;
		status_t          st;
		logic [POS_W-1:0] pos;
	} dir_row_t;

	localparam int DIR_ROWS = 27;
	localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		// Reset configuration: no bar delimiter, escapes on.
		'{2'b00, "a",          1'b0, 1'b1, 1'b1, ST_CONT,    17'd0},
		'{2'b00, CH_RPAREN,    1'b0, 1'b0, 1'b1, ST_FOUND,   17'd2},
		'{2'b00, "x",          1'b0, 1'b0, 1'b1, ST_IGNORED, 17'd0},
		// Limit on the very first character is a plain no-match.
		'{2'b00, "a",          1'b1, 1'b1, 1'b1, ST_NOMATCH, 17'd0},
		// Sub-bracket [= ... ], then the limit lands on the skipped character.
		'{2'b00, CH_LBRACKET,  1'b0, 1'b1, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_LBRACKET,  1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_EQUAL,     1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_RPAREN,    1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_RBRACKET,  1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, "q",          1'b1, 1'b0, 1'b1, ST_LIMIT,   17'd5},
		// Escaped close, then an unterminated [: sub-bracket hit by NUL.
		'{2'b00, CH_BACKSLASH, 1'b0, 1'b1, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_RPAREN,    1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_LBRACKET,  1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_LBRACKET,  1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_COLON,     1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_NUL,       1'b0, 1'b0, 1'b1, ST_NOMATCH, 17'd0},
		// Balanced parens around the top byte; NUL together with the limit.
		'{2'b00, CH_LPAREN,    1'b0, 1'b1, 1'b0, ST_CONT,    17'd0},
		'{2'b00, 8'hFF,        1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_RPAREN,    1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b00, CH_NUL,       1'b1, 1'b0, 1'b1, ST_NOMATCH, 17'd0},
		// Bar delimiter on, escapes off.
		'{2'b11, CH_BAR,       1'b0, 1'b1, 1'b1, ST_FOUND,   17'd1},
		'{2'b11, CH_BACKSLASH, 1'b0, 1'b1, 1'b0, ST_CONT,    17'd0},
		'{2'b11, CH_BAR,       1'b0, 1'b0, 1'b1, ST_FOUND,   17'd2},
		'{2'b11, CH_LPAREN,    1'b0, 1'b1, 1'b0, ST_CONT,    17'd0},
		'{2'b11, CH_BAR,       1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b11, CH_RPAREN,    1'b0, 1'b0, 1'b0, ST_CONT,    17'd0},
		'{2'b11, CH_RPAREN,    1'b0, 1'b0, 1'b1, ST_FOUND,   17'd4}
	};

	localparam cfg_t PHASE_CFG [0:3] = '{2'b10, 2'b01, 2'b00, 2'b11};

	function automatic void clear_scan_state();
		sc_mode  = MODE_NORMAL;
		sc_esc   = 1'b0;
		sc_depth = '0;
		sc_idx   = '0;
	endfunction

	// Handling of one character outside a sub-bracket: escapes, bracket
	// entry and exit, paren depth and the two delimiters.
	function automatic status_t plain_step(input logic [7:0] c, output logic [POS_W-1:0] pos);
		pos = '0;
		if (sc_esc) begin
			sc_esc = 1'b0;
			return ST_CONT;
		end
		if (c == CH_BACKSLASH && !cfg_shadow.no_escape) begin
			sc_esc = 1'b1;
			return ST_CONT;
		end
		if (sc_mode == MODE_BRACKET) begin
			if (c == CH_LBRACKET)
				sc_mode = MODE_BRACKET_LB;
			else if (c == CH_RBRACKET)
				sc_mode = MODE_NORMAL;
			return ST_CONT;
		end
		if (c == CH_LBRACKET) begin
			sc_mode = MODE_BRACKET;
		end else if (c == CH_LPAREN) begin
			if (sc_depth < MAX_PAREN_DEPTH)
				sc_depth = sc_depth + 8'd1;
		end else if (c == CH_RPAREN) begin
			if (sc_depth == 0) begin
				pos = sc_idx + 17'd1;
				return ST_FOUND;
			end
			sc_depth = sc_depth - 8'd1;
		end else if (c == CH_BAR && sc_depth == 0 && cfg_shadow.delim_is_bar) begin
			pos = sc_idx + 17'd1;
			return ST_FOUND;
		end
		return ST_CONT;
	endfunction

	// Advances the shadow scanner by one accepted item and returns the
	// result the block must produce for it.
	function automatic result_t scan_predict(input logic [7:0] c, input logic lim,
	                                         input logic first);
		status_t          st;
		logic [POS_W-1:0] pos;
		st  = ST_CONT;
		pos = '0;
		if (first) begin
			clear_scan_state();
			if (lim) begin
				sc_mode = MODE_DONE;
				st = ST_NOMATCH;
			end
		end else if (sc_mode == MODE_DONE) begin
			st = ST_IGNORED;
		end
		if (st == ST_CONT && sc_mode != MODE_DONE) begin
			if (c == CH_NUL) begin
				st = ST_NOMATCH;
			end else if (lim) begin
				st  = ST_LIMIT;
				pos = sc_idx;
			end else begin
				case (sc_mode)
					MODE_SKIP_AFTER: sc_mode = MODE_BRACKET;
					MODE_SUB: begin
						if (c == CH_RBRACKET)
							sc_mode = MODE_SKIP_AFTER;
					end
					MODE_BRACKET_LB: begin
						if (c == CH_COLON || c == CH_DOT || c == CH_EQUAL) begin
							sc_mode = MODE_SUB;
						end else begin
							sc_mode = MODE_BRACKET;
							st = plain_step(c, pos);
						end
					end
					default: st = plain_step(c, pos);
				endcase
			end
			if (st != ST_CONT)
				sc_mode = MODE_DONE;
			else if (sc_idx < MAX_PATTERN_LEN - 1)
				sc_idx = sc_idx + 17'd1;
		end
		return '{st, pos};
	endfunction

	// Random pattern character. The current scan mode steers the choice so
	// that sub-brackets are opened and closed often enough to matter.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (sc_mode == MODE_BRACKET_LB && r < 60) begin
			case (r % 3)
				0:       return CH_COLON;
				1:       return CH_DOT;
				default: return CH_EQUAL;
			endcase
		end
		if (sc_mode == MODE_SUB && r < 30)
			return CH_RBRACKET;
		if (r < 2)
			return CH_NUL;
		if (r < 14)
			return 8'($urandom_range(1, 255));
		case (r % 11)
			0:       return CH_BACKSLASH;
			1:       return CH_LBRACKET;
			2:       return CH_RBRACKET;
			3:       return CH_LPAREN;
			4:       return CH_RPAREN;
			5:       return CH_BAR;
			6:       return CH_COLON;
			7:       return CH_DOT;
			8:       return CH_EQUAL;
			default: return 8'h61 + 8'(r % 26);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (mismatch_cnt < 50)
			$display("mismatch in %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		mismatch_cnt++;
	endtask

	// Offers one item and waits for its handshake. The sender runs in bursts;
	// when a burst is used up it usually drops valid for a random gap first.
	// A known result, where given, replaces the prediction as the expectation.
	task automatic send_char(input logic [7:0] c, input logic lim, input logic first,
	                         input logic known, input result_t known_res);
		result_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= {first, lim};
		do @(posedge clk); while (!s_tready);
		r = scan_predict(c, lim, first);
		last_status = r.status;
		pending_scan_results.push_back(known ? known_res : r);
		burst_left--;
	endtask

	// Stops offering and waits until the block has returned every result.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_scan_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes both registers while the block is idle, then follows in the shadow.
	task automatic set_config(input cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELIM_IS_BAR;
		cfg_data  <= c.delim_is_bar;
		@(posedge clk);
		cfg_index <= CFG_NO_ESCAPE;
		cfg_data  <= c.no_escape;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	// Receiver: a stall pattern whose style is redrawn at random intervals,
	// overridden by a long hold-off whenever the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_served != hold_reqs && hold_left == 0) begin
			hold_left   = HOLD_CYCLES;
			hold_served = hold_reqs;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_left  = $urandom_range(32, 400);
			end
			rx_left--;
			case (rx_style)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ((rx_left % 8) < 5);
			endcase
		end
	end

	// Result checker: every accepted result is matched with the oldest
	// expectation, field by field, including the zero fill above position.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_scan_results.size() == 0) begin
				report_mismatch("unexpected result status", 32'(m_tuser), 32'd0);
			end else begin
				want = pending_scan_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				if (m_tdata[POS_W-1:0] != want.position)
					report_mismatch("position", 32'(m_tdata[POS_W-1:0]),
					                32'(want.position));
				if (m_tdata[23:POS_W] != '0)
					report_mismatch("tdata fill", 32'(m_tdata[23:POS_W]), 32'd0);
			end
		end
	end

	// Watchdog on cycles in which no item moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("glob_pattern_delimiter_scan verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int  ph;
		int  k;
		int  len;
		int  lim_at;
		int  counted;
		bit  hold_done;
		dir_row_t row;

		hold_done = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_DELIM_IS_BAR;
		cfg_data  = '0;
		arst_n    = 1'b0;
		cfg_shadow = '0;
		clear_scan_state();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. The first rows run on the reset configuration;
		// a row that needs another setting waits for the block to go idle.
		for (k = 0; k < DIR_ROWS; k++) begin
			row = DIR_TABLE[k];
			if (row.cfg != cfg_shadow) begin
				drain_results();
				set_config(row.cfg);
			end
			send_char(row.ch, row.lim, row.first, row.known, '{row.st, row.pos});
		end

		// Random phases, each on its own setting. Most of the traffic is
		// whole scans with random content; one burst in five is raw noise with
		// random first and limit flags. Ignored items are not counted.
		for (ph = 0; ph < 6; ph++) begin
			drain_results();
			if (ph < 4)
				set_config(PHASE_CFG[ph]);
			else
				set_config(cfg_t'(2'($urandom_range(0, 3))));
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8) begin
					len    = $urandom_range(1, 24);
					lim_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
					for (k = 0; k < len; k++) begin
						send_char(pick_char(), k == lim_at, k == 0, 1'b0, '0);
						if (last_status != ST_IGNORED)
							counted++;
						// Usually move on once the scan has ended, sometimes
						// keep going to see ignored items.
						if (sc_mode == MODE_DONE && $urandom_range(0, 7) != 0)
							break;
					end
				end else begin
					len = $urandom_range(1, 6);
					for (k = 0; k < len; k++) begin
						send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						          $urandom_range(0, 2) == 0, 1'b0, '0);
						if (last_status != ST_IGNORED)
							counted++;
					end
				end
				// Long receiver hold-off while the sender keeps offering, so
				// that both internal registers fill and the input stalls.
				if (ph == 0 && !hold_done && counted >= 60) begin
					hold_reqs++;
					hold_done = 1'b1;
				end
			end

			if (ph == 0) begin
				// Paren depth saturation: 300 opens count only to the maximum,
				// so the maximum number of closes plus one ends the scan.
				send_char("a", 1'b0, 1'b1, 1'b0, '0);
				repeat (300) send_char(CH_LPAREN, 1'b0, 1'b0, 1'b0, '0);
				repeat (MAX_PAREN_DEPTH + 1) send_char(CH_RPAREN, 1'b0, 1'b0, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("glob_pattern_delimiter_scan verification clean");
		else
			$display("glob_pattern_delimiter_scan verification failed");
		$finish;
	end

endmodule
